>>> rtl/kct_pkg.sv
package kct_pkg;

    // default sizing
    localparam int CAPACITY_DEF    = 32;
    localparam int VALUE_WIDTH_DEF = 32;

    // most matches one collect lists
    localparam int MAX_RESULTS = 32;

    // action codes
    localparam logic [2:0] ACT_INSERT  = 3'd0;
    localparam logic [2:0] ACT_LOOKUP  = 3'd1;
    localparam logic [2:0] ACT_COLLECT = 3'd2;
    localparam logic [2:0] ACT_POP     = 3'd3;
    localparam logic [2:0] ACT_CLEAR   = 3'd4;

    // status codes
    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_REPLACED  = 3'd1;
    localparam logic [2:0] ST_FOUND     = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_OVERFLOW  = 3'd4;
    localparam logic [2:0] ST_MATCH     = 3'd5;
    localparam logic [2:0] ST_NO_MATCH  = 3'd6;
    localparam logic [2:0] ST_DONE      = 3'd7;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] key_family;
        logic [15:0] key_name;
        logic [15:0] key_checksum;
        logic [31:0] entry_value;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [4:0]  entry_index;
        logic [31:0] found_value;
        logic [15:0] found_name;
        logic [5:0]  entry_count;
        logic        load_error;
        logic        last;
    } t_out_item;

    // store port control
    typedef struct packed {
        logic rd_en;
        logic wr_key;
        logic wr_val;
    } t_store_ctl;

endpackage

>>> rtl/kct_store.sv
module kct_store #(
    parameter int CAPACITY    = kct_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = kct_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                            i_clk,
    input  kct_pkg::t_store_ctl                             i_ctl,
    input  logic [$clog2(CAPACITY > 1 ? CAPACITY : 2)-1:0]  i_addr,
    input  logic [47:0]                                     i_wkey,
    input  logic [VALUE_WIDTH-1:0]                          i_wval,
    output logic [47:0]                                     o_rkey,
    output logic [VALUE_WIDTH-1:0]                          o_rval
);
    import kct_pkg::*;

    logic [47:0]            r_key_mem [CAPACITY];
    logic [VALUE_WIDTH-1:0] r_val_mem [CAPACITY];
    logic [47:0]            r_rkey;
    logic [VALUE_WIDTH-1:0] r_rval;

    // one address per cycle, read data registered and held while not read
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_key) begin
            r_key_mem[i_addr] <= i_wkey;
        end
        if (i_ctl.wr_val) begin
            r_val_mem[i_addr] <= i_wval;
        end
        if (i_ctl.rd_en) begin
            r_rkey <= r_key_mem[i_addr];
            r_rval <= r_val_mem[i_addr];
        end
    end

    assign o_rkey = r_rkey;
    assign o_rval = r_rval;

endmodule

>>> rtl/kct_ctrl.sv
module kct_ctrl #(
    parameter int CAPACITY    = kct_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = kct_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_in_valid,
    output logic                                            o_in_ready,
    input  kct_pkg::t_in_item                               i_in_item,
    output logic                                            o_res_valid,
    input  logic                                            i_res_ready,
    output kct_pkg::t_out_item                              o_res,
    output kct_pkg::t_store_ctl                             o_st_ctl,
    output logic [$clog2(CAPACITY > 1 ? CAPACITY : 2)-1:0]  o_st_addr,
    output logic [47:0]                                     o_st_wkey,
    output logic [VALUE_WIDTH-1:0]                          o_st_wval,
    input  logic [47:0]                                     i_st_rkey,
    input  logic [VALUE_WIDTH-1:0]                          i_st_rval
);
    import kct_pkg::*;

    localparam int IW = $clog2(CAPACITY > 1 ? CAPACITY : 2);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = $clog2(MAX_RESULTS + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_REPLY = 2'd2;

    logic [1:0]             r_state,      n_state;
    logic [2:0]             r_act,        n_act;
    logic [47:0]            r_key,        n_key;
    logic [VALUE_WIDTH-1:0] r_val,        n_val;
    logic [CW-1:0]          r_count,      n_count;
    logic                   r_ovf,        n_ovf;
    logic [CW-1:0]          r_rd_idx,     n_rd_idx;
    logic                   r_cmp_vld,    n_cmp_vld;
    logic [IW-1:0]          r_cmp_idx,    n_cmp_idx;
    logic                   r_pend,       n_pend;
    logic [IW-1:0]          r_pend_idx,   n_pend_idx;
    logic [VALUE_WIDTH-1:0] r_pend_val,   n_pend_val;
    logic [15:0]            r_pend_name,  n_pend_name;
    logic [KW-1:0]          r_k,          n_k;
    logic [2:0]             r_res_status, n_res_status;
    logic [IW-1:0]          r_res_idx,    n_res_idx;
    logic [VALUE_WIDTH-1:0] r_res_val,    n_res_val;
    logic [15:0]            r_res_name,   n_res_name;

    logic                   match_full;
    logic                   match_fc;
    logic                   scan_done;
    logic                   stop;
    logic                   stall;
    logic [2:0]             res_status;
    logic [IW-1:0]          res_idx;
    logic [VALUE_WIDTH-1:0] res_val;
    logic [15:0]            res_name;
    logic                   res_last;

    assign match_full = r_cmp_vld && (i_st_rkey == r_key);
    assign match_fc   = r_cmp_vld && (i_st_rkey[47:32] == r_key[47:32])
                        && (i_st_rkey[15:0] == r_key[15:0]);
    assign scan_done  = !r_cmp_vld && (r_rd_idx >= r_count);

    always_comb begin
        n_state      = r_state;
        n_act        = r_act;
        n_key        = r_key;
        n_val        = r_val;
        n_count      = r_count;
        n_ovf        = r_ovf;
        n_rd_idx     = r_rd_idx;
        n_cmp_vld    = r_cmp_vld;
        n_cmp_idx    = r_cmp_idx;
        n_pend       = r_pend;
        n_pend_idx   = r_pend_idx;
        n_pend_val   = r_pend_val;
        n_pend_name  = r_pend_name;
        n_k          = r_k;
        n_res_status = r_res_status;
        n_res_idx    = r_res_idx;
        n_res_val    = r_res_val;
        n_res_name   = r_res_name;
        o_in_ready   = 1'b0;
        o_res_valid  = 1'b0;
        o_st_ctl     = '0;
        o_st_addr    = r_rd_idx[IW-1:0];
        o_st_wkey    = r_key;
        o_st_wval    = r_val;
        stop         = 1'b0;
        stall        = 1'b0;
        res_status   = ST_MATCH;
        res_idx      = r_pend_idx;
        res_val      = r_pend_val;
        res_name     = r_pend_name;
        res_last     = 1'b0;

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_act        = i_in_item.action;
                    n_key        = {i_in_item.key_family, i_in_item.key_name,
                                    i_in_item.key_checksum};
                    n_val        = VALUE_WIDTH'(i_in_item.entry_value);
                    n_rd_idx     = '0;
                    n_cmp_vld    = 1'b0;
                    n_pend       = 1'b0;
                    n_k          = '0;
                    n_res_status = ST_DONE;
                    n_res_idx    = '0;
                    n_res_val    = '0;
                    n_res_name   = '0;
                    case (i_in_item.action)
                        ACT_INSERT, ACT_LOOKUP, ACT_COLLECT: begin
                            n_state = S_SCAN;
                        end
                        ACT_POP: begin
                            if (r_count != '0) begin
                                n_count = r_count - 1'b1;
                            end
                            n_state = S_REPLY;
                        end
                        ACT_CLEAR: begin
                            n_count = '0;
                            n_state = S_REPLY;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (r_act == ACT_INSERT && match_full) begin
                    o_st_ctl.wr_val = 1'b1;
                    o_st_addr       = r_cmp_idx;
                    n_res_status    = ST_REPLACED;
                    n_res_idx       = r_cmp_idx;
                    n_res_val       = r_val;
                    n_state         = S_REPLY;
                    stop            = 1'b1;
                end else if (r_act == ACT_LOOKUP && match_full) begin
                    n_res_status = ST_FOUND;
                    n_res_idx    = r_cmp_idx;
                    n_res_val    = i_st_rval;
                    n_state      = S_REPLY;
                    stop         = 1'b1;
                end else if (r_act == ACT_COLLECT && match_fc) begin
                    // the held match goes out once a later one shows it is not last
                    o_res_valid = r_pend;
                    if (r_pend && !i_res_ready) begin
                        stall = 1'b1;
                    end else begin
                        n_pend      = 1'b1;
                        n_pend_idx  = r_cmp_idx;
                        n_pend_val  = i_st_rval;
                        n_pend_name = i_st_rkey[31:16];
                        n_k         = r_k + 1'b1;
                        if (r_k == KW'(MAX_RESULTS - 1)) begin
                            n_res_status = ST_MATCH;
                            n_res_idx    = r_cmp_idx;
                            n_res_val    = i_st_rval;
                            n_res_name   = i_st_rkey[31:16];
                            n_state      = S_REPLY;
                            stop         = 1'b1;
                        end
                    end
                end else if (scan_done) begin
                    stop    = 1'b1;
                    n_state = S_REPLY;
                    case (r_act)
                        ACT_INSERT: begin
                            if (r_count < CW'(CAPACITY)) begin
                                o_st_ctl.wr_key = 1'b1;
                                o_st_ctl.wr_val = 1'b1;
                                o_st_addr       = r_count[IW-1:0];
                                n_count         = r_count + 1'b1;
                                n_res_status    = ST_INSERTED;
                                n_res_idx       = r_count[IW-1:0];
                                n_res_val       = r_val;
                            end else begin
                                n_ovf        = 1'b1;
                                n_res_status = ST_OVERFLOW;
                            end
                        end
                        ACT_LOOKUP: begin
                            n_res_status = ST_NOT_FOUND;
                        end
                        default: begin
                            if (r_pend) begin
                                n_res_status = ST_MATCH;
                                n_res_idx    = r_pend_idx;
                                n_res_val    = r_pend_val;
                                n_res_name   = r_pend_name;
                            end else begin
                                n_res_status = ST_NO_MATCH;
                            end
                        end
                    endcase
                end

                // read one entry a cycle unless stopped or stalled by a held collect match, compared in the next cycle
                if (!stop && !stall) begin
                    if (r_rd_idx < r_count) begin
                        o_st_ctl.rd_en = 1'b1;
                        n_cmp_vld      = 1'b1;
                        n_cmp_idx      = r_rd_idx[IW-1:0];
                        n_rd_idx       = r_rd_idx + 1'b1;
                    end else begin
                        n_cmp_vld = 1'b0;
                    end
                end
            end

            S_REPLY: begin
                o_res_valid = 1'b1;
                res_status  = r_res_status;
                res_idx     = r_res_idx;
                res_val     = r_res_val;
                res_name    = r_res_name;
                res_last    = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_res.status      = res_status;
        o_res.entry_index = 5'(res_idx);
        o_res.found_value = 32'(res_val);
        o_res.found_name  = res_name;
        o_res.entry_count = 6'(r_count);
        o_res.load_error  = r_ovf;
        o_res.last        = res_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_cmp_vld <= 1'b0;
            r_pend    <= 1'b0;
            r_k       <= '0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_ovf     <= n_ovf;
            r_cmp_vld <= n_cmp_vld;
            r_pend    <= n_pend;
            r_k       <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act        <= n_act;
        r_key        <= n_key;
        r_val        <= n_val;
        r_rd_idx     <= n_rd_idx;
        r_cmp_idx    <= n_cmp_idx;
        r_pend_idx   <= n_pend_idx;
        r_pend_val   <= n_pend_val;
        r_pend_name  <= n_pend_name;
        r_res_status <= n_res_status;
        r_res_idx    <= n_res_idx;
        r_res_val    <= n_res_val;
        r_res_name   <= n_res_name;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_no_rd_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_st_ctl.rd_en && (o_st_ctl.wr_key || o_st_ctl.wr_val)))
        else $error("store read and write in one cycle");

    a_match_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k <= KW'(MAX_RESULTS))
        else $error("collect listed too many matches");

    a_ovf_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status == ST_OVERFLOW) |-> r_ovf)
        else $error("overflow reported without sticky flag");

    a_res_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (r_state == S_SCAN || r_state == S_REPLY))
        else $error("result offered while idle");

endmodule

>>> rtl/keyed_config_table.sv
// keyed_config_table: table of up to CAPACITY entries, each a 48-bit key
// (family, name, checksum) and a VALUE_WIDTH-bit value, searched linearly.
// input channel i_in_valid / o_in_ready carries one item: an action and its
// key and value. output channel o_out_valid / i_out_ready carries result items.
// insert, lookup, pop and clear give one result each; collect gives one result
// per matching entry in table order (at most MAX_RESULTS), or one no-match
// result, with last set on the final one. unknown actions are dropped and
// give no result. one item is worked on at a time; o_in_ready is high only
// between items. pop and clear go from accept straight to their result;
// insert, lookup and collect walk the stored entries one per cycle through
// the single-port key and value memories, pausing only when a collect stalls
// as below; insert or lookup stop early on a hit.
// results pass through an output register, so the last result of one item
// may wait there while the next item is accepted; while the receiver stalls,
// a collect walk pauses at the next match until the register frees up.
// reset empties the table and clears the sticky overflow flag; memory
// contents are left as they are, since only entries below the fill count
// are ever read.
module keyed_config_table #(
    parameter int CAPACITY    = kct_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = kct_pkg::VALUE_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  kct_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output kct_pkg::t_out_item o_out_item
);
    import kct_pkg::*;

    localparam int IW = $clog2(CAPACITY > 1 ? CAPACITY : 2);

    // controller to store
    t_store_ctl             st_ctl;
    logic [IW-1:0]          st_addr;
    logic [47:0]            st_wkey;
    logic [VALUE_WIDTH-1:0] st_wval;
    logic [47:0]            st_rkey;
    logic [VALUE_WIDTH-1:0] st_rval;

    // controller to output register
    logic      res_valid;
    logic      res_ready;
    t_out_item res;

    // output register
    logic      r_o_valid;
    t_out_item r_o_item;

    kct_ctrl #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_st_ctl    (st_ctl),
        .o_st_addr   (st_addr),
        .o_st_wkey   (st_wkey),
        .o_st_wval   (st_wval),
        .i_st_rkey   (st_rkey),
        .i_st_rval   (st_rval)
    );

    kct_store #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_ctl  (st_ctl),
        .i_addr (st_addr),
        .i_wkey (st_wkey),
        .i_wval (st_wval),
        .o_rkey (st_rkey),
        .o_rval (st_rval)
    );

    // register takes a new item when empty or emptying this cycle
    assign res_ready = !r_o_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    // payload loads only with a new item, holds while stalled
    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_o_item <= res;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_item  = r_o_item;

endmodule
